// ===== hdl/kalman_angle_fusion_assert.svh =====
// Assertion macros for the angle fusion filter
`ifndef KALMAN_ANGLE_FUSION_ASSERT_SVH
`define KALMAN_ANGLE_FUSION_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define KAF_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("kalman_angle_fusion assertion failed");
// Next-cycle implication, sampled on clk, off during reset
`define KAF_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("kalman_angle_fusion assertion failed");
`else
`define KAF_ASSERT_IMP(lbl, ant, cons)
`define KAF_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

// ===== hdl/kaf_pkg.sv =====
// Types, constants and fixed-point helpers of the angle fusion filter
package kaf_pkg;

	localparam int DT_FRAC_BITS  = 16;
	localparam int COV_FRAC_BITS = 28;

	// Register indexes
	localparam logic [1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic [30:0] ANGLE_NOISE_RST = 31'd268435;
	localparam logic [30:0] BIAS_NOISE_RST  = 31'd805306;
	localparam logic [30:0] MEAS_NOISE_RST  = 31'd8053064;

	// Datapath operations, one per controller step
	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_RATE, OP_M1, OP_M2, OP_INNER, OP_M3, OP_M4, OP_P11,
		OP_S, OP_DIV0, OP_WAIT0, OP_DIV1, OP_WAIT1, OP_M5, OP_M6, OP_M7, OP_M8,
		OP_M9, OP_M10, OP_C11, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RATE, ST_M1, ST_M2, ST_INNER, ST_M3, ST_M4, ST_P11, ST_S,
		ST_DIV0, ST_WAIT0, ST_DIV1, ST_WAIT1, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
		ST_M10, ST_C11, ST_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Round to nearest, ties up, after a product in time-step format
	function automatic logic signed [63:0] rnd_dt(input logic signed [67:0] p);
		logic signed [67:0] t;
		logic signed [67:0] sh;
		t = p + (68'sd1 <<< (DT_FRAC_BITS - 1));
		sh = t >>> DT_FRAC_BITS;
		return sh[63:0];
	endfunction

	// Same after a product in covariance format
	function automatic logic signed [63:0] rnd_cov(input logic signed [67:0] p);
		logic signed [67:0] t;
		logic signed [67:0] sh;
		t = p + (68'sd1 <<< (COV_FRAC_BITS - 1));
		sh = t >>> COV_FRAC_BITS;
		return sh[63:0];
	endfunction

endpackage

// ===== hdl/kaf_div.sv =====
// Restoring divider for the gains: sat32(num * 2^COV_FRAC_BITS / den), den > 0
module kaf_div import kaf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [32:0] den,
	output logic               done,
	output logic signed [31:0] quot
);

	localparam int DVD_W = 32 + COV_FRAC_BITS;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        cnt_q;
	logic [33:0]       rem_q;
	logic [31:0]       low_q;
	logic [32:0]       den_q;
	logic              neg_q;
	logic              ovf_q;

	logic [31:0]       mag;
	logic [DVD_W-1:0]  dvd;
	logic [33:0]       trial;
	logic              qbit;

	// Dividend magnitude, trial remainder and quotient bit
	always_comb begin
		mag = num[31] ? 32'(-num) : 32'(num);
		dvd = {mag, {COV_FRAC_BITS{1'b0}}};
		trial = {rem_q[32:0], low_q[31]};
		qbit = trial >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 34'(dvd >> 32);
			low_q <= dvd[31:0];
			den_q <= den;
			neg_q <= num[31];
			ovf_q <= {(65 - DVD_W)'(0), dvd} >= {den, 32'd0};
		end else if (busy_q) begin
			rem_q <= qbit ? trial - {1'b0, den_q} : trial;
			low_q <= {low_q[30:0], qbit};
		end
	end

	// Sign and saturation
	always_comb begin
		if (neg_q) begin
			quot = (ovf_q || low_q > 32'h80000000) ? 32'sh80000000 : -$signed(low_q);
		end else begin
			quot = (ovf_q || low_q[31]) ? 32'sh7fffffff : $signed(low_q);
		end
	end

	assign done = done_q;

endmodule

// ===== hdl/kaf_datapath.sv =====
// Filter datapath: state, registers, shared multiplier and gain divider
module kaf_datapath import kaf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [30:0] cfg_data,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	input  logic        [15:0] time_step,
	output logic signed [31:0] estimated_angle
);

	logic        [30:0] qa_q, qb_q, r_q;
	logic signed [31:0] angle_q, bias_q, c00_q, c01_q, c10_q, c11_q;
	logic signed [31:0] ma_q, mr_q;
	logic        [15:0] dt_q;
	logic signed [31:0] rate_q, y_q, k0_q, k1_q;
	logic signed [31:0] p00_q, p01_q, p10_q, p11_q;
	logic signed [33:0] inner_q, s_q;
	logic signed [67:0] prod_q;
	logic signed [31:0] out_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [33:0] dt_x;
	logic signed [63:0] r16, r28;
	logic               div_start, div_done;
	logic signed [31:0] div_num, quot;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			r_q <= MEAS_NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ANGLE_NOISE: qa_q <= cfg_data;
				CFG_BIAS_NOISE:  qb_q <= cfg_data;
				CFG_MEAS_NOISE:  r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Multiplier operand select
	always_comb begin
		dt_x = $signed({18'd0, dt_q});
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_M1:  begin mul_a = dt_x; mul_b = 34'(rate_q); end
			OP_M2:  begin mul_a = dt_x; mul_b = 34'(c11_q); end
			OP_M3:  begin mul_a = dt_x; mul_b = inner_q; end
			OP_M4:  begin mul_a = $signed({3'd0, qb_q}); mul_b = dt_x; end
			OP_M5:  begin mul_a = 34'(k0_q); mul_b = 34'(y_q); end
			OP_M6:  begin mul_a = 34'(k1_q); mul_b = 34'(y_q); end
			OP_M7:  begin mul_a = 34'(k0_q); mul_b = 34'(p00_q); end
			OP_M8:  begin mul_a = 34'(k0_q); mul_b = 34'(p01_q); end
			OP_M9:  begin mul_a = 34'(k1_q); mul_b = 34'(p00_q); end
			OP_M10: begin mul_a = 34'(k1_q); mul_b = 34'(p01_q); end
			default: ;
		endcase
	end

	assign r16 = rnd_dt(prod_q);
	assign r28 = rnd_cov(prod_q);

	// Product register and working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				ma_q <= measured_angle;
				mr_q <= measured_rate;
				dt_q <= time_step;
			end
			OP_RATE:  rate_q <= sat32(64'(mr_q) - 64'(bias_q));
			OP_INNER: begin
				inner_q <= 34'(r16 - 64'(c01_q) - 64'(c10_q) + $signed({33'd0, qa_q}));
				p01_q <= sat32(64'(c01_q) - r16);
				p10_q <= sat32(64'(c10_q) - r16);
			end
			OP_M4:  p00_q <= sat32(64'(c00_q) + r16);
			OP_P11: p11_q <= sat32(64'(c11_q) + r16);
			OP_S: begin
				s_q <= 34'(64'(p00_q) + $signed({33'd0, r_q}));
				y_q <= sat32(64'(ma_q) - 64'(angle_q));
			end
			OP_WAIT0: if (div_done) k0_q <= (s_q > 34'sd0) ? quot : 32'sd0;
			OP_WAIT1: if (div_done) k1_q <= (s_q > 34'sd0) ? quot : 32'sd0;
			OP_OUT: out_q <= angle_q;
			default: ;
		endcase
	end

	// Filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q <= '0;
			c00_q <= '0;
			c01_q <= '0;
			c10_q <= '0;
			c11_q <= '0;
		end else begin
			case (cmd.op)
				OP_M2:  angle_q <= sat32(64'(angle_q) + r16);
				OP_M6:  angle_q <= sat32(64'(angle_q) + r28);
				OP_M7:  bias_q <= sat32(64'(bias_q) + r28);
				OP_M8:  c00_q <= sat32(64'(p00_q) - r28);
				OP_M9:  c01_q <= sat32(64'(p01_q) - r28);
				OP_M10: c10_q <= sat32(64'(p10_q) - r28);
				OP_C11: c11_q <= sat32(64'(p11_q) - r28);
				default: ;
			endcase
		end
	end

	// Gain divider
	assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
	assign div_num = (cmd.op == OP_DIV1) ? p10_q : p00_q;

	kaf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q[32:0]),
		.done   (div_done),
		.quot   (quot)
	);

	assign stat.div_done = div_done;
	assign estimated_angle = out_q;

endmodule

// ===== hdl/kaf_ctrl.sv =====
// Filter sequencer: steps the datapath through one update, drives handshakes
module kaf_ctrl import kaf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_RATE;
			ST_RATE:  state_d = ST_M1;
			ST_M1:    state_d = ST_M2;
			ST_M2:    state_d = ST_INNER;
			ST_INNER: state_d = ST_M3;
			ST_M3:    state_d = ST_M4;
			ST_M4:    state_d = ST_P11;
			ST_P11:   state_d = ST_S;
			ST_S:     state_d = ST_DIV0;
			ST_DIV0:  state_d = ST_WAIT0;
			ST_WAIT0: if (stat.div_done) state_d = ST_DIV1;
			ST_DIV1:  state_d = ST_WAIT1;
			ST_WAIT1: if (stat.div_done) state_d = ST_M5;
			ST_M5:    state_d = ST_M6;
			ST_M6:    state_d = ST_M7;
			ST_M7:    state_d = ST_M8;
			ST_M8:    state_d = ST_M9;
			ST_M9:    state_d = ST_M10;
			ST_M10:   state_d = ST_C11;
			ST_C11:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			ST_RATE:  cmd.op = OP_RATE;
			ST_M1:    cmd.op = OP_M1;
			ST_M2:    cmd.op = OP_M2;
			ST_INNER: cmd.op = OP_INNER;
			ST_M3:    cmd.op = OP_M3;
			ST_M4:    cmd.op = OP_M4;
			ST_P11:   cmd.op = OP_P11;
			ST_S:     cmd.op = OP_S;
			ST_DIV0:  cmd.op = OP_DIV0;
			ST_WAIT0: cmd.op = OP_WAIT0;
			ST_DIV1:  cmd.op = OP_DIV1;
			ST_WAIT1: cmd.op = OP_WAIT1;
			ST_M5:    cmd.op = OP_M5;
			ST_M6:    cmd.op = OP_M6;
			ST_M7:    cmd.op = OP_M7;
			ST_M8:    cmd.op = OP_M8;
			ST_M9:    cmd.op = OP_M9;
			ST_M10:   cmd.op = OP_M10;
			ST_C11:   cmd.op = OP_C11;
			ST_DONE:  if (out_free) cmd.op = OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// State and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/kalman_angle_fusion.sv =====
// Top level of the two-state angle and gyro bias fusion filter
//
//   channel   direction  handshake            payload
//   in        receive    in_valid/in_stall    measured_angle, measured_rate, time_step
//   out       send       out_valid/out_stall  estimated_angle
//   cfg       receive    cfg_we               cfg_index, cfg_data
//
// One update runs the restoring divider once per gain; the rest is one
// shared 34x34 multiplier step per cycle, until the result waits on a
// stalled output. Items are taken one at a time.
// Reset is asynchronous; the state clears and the noise registers load defaults.
// A stalled result sits in the output register while the next item is taken.
`include "kalman_angle_fusion_assert.svh"

module kalman_angle_fusion import kaf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] measured_angle,
	input  logic signed [31:0] measured_rate,
	input  logic        [15:0] time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] estimated_angle,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [30:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	kaf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	kaf_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.measured_angle  (measured_angle),
		.measured_rate   (measured_rate),
		.time_step       (time_step),
		.estimated_angle (estimated_angle)
	);

	// A transfer in makes the block busy for the next cycle
	`KAF_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// Divider completion only lands while a gain is awaited
	`KAF_ASSERT_IMP(a_div_done_wait, stat.div_done, cmd.op == OP_WAIT0 || cmd.op == OP_WAIT1)
	// The output register is loaded only when it is free
	`KAF_ASSERT_IMP(a_out_load_free, cmd.op == OP_OUT, !out_valid || !out_stall)

endmodule
